/* design/ddp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_pkg
// Shared types and constants of the display protocol packetizer.
// ----------------------------------------------------------------------------
package ddp_pkg;

   localparam int CSR_DATA_W = 25;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLED     = 3'd0,
      CSR_CHAN_COUNT  = 3'd1,
      CSR_START_CHAN  = 3'd2,
      CSR_KEEP_OFFSET = 3'd3,
      CSR_PKT_SIZE    = 3'd4
   } csr_index_type;

   localparam logic [10:0] MAX_PAYLOAD  = 11'd1440;
   localparam logic [7:0]  FLAG_VERSION = 8'h40;
   localparam logic [7:0]  FLAG_PUSH    = 8'h01;
   localparam logic [7:0]  DATA_TYPE    = 8'h01;
   localparam logic [7:0]  DISPLAY_ID   = 8'h01;
   localparam logic [3:0]  SEQ_FIRST    = 4'd1;
   localparam logic [3:0]  SEQ_MAX      = 4'd15;

   localparam logic [3:0] BEAT_FLAGS = 4'd0;
   localparam logic [3:0] BEAT_SEQ   = 4'd1;
   localparam logic [3:0] BEAT_TYPE  = 4'd2;
   localparam logic [3:0] BEAT_ID    = 4'd3;
   localparam logic [3:0] BEAT_OFF3  = 4'd4;
   localparam logic [3:0] BEAT_OFF2  = 4'd5;
   localparam logic [3:0] BEAT_OFF1  = 4'd6;
   localparam logic [3:0] BEAT_OFF0  = 4'd7;
   localparam logic [3:0] BEAT_LEN1  = 4'd8;
   localparam logic [3:0] BEAT_LEN0  = 4'd9;
   localparam logic [3:0] BEAT_DATA  = 4'd10;

   typedef struct packed {
      logic        has_hdr;
      logic [7:0]  flags;
      logic [3:0]  seq;
      logic [31:0] offset;
      logic [10:0] len;
      logic [7:0]  data;
      logic        pend;
      logic        fend;
   } ddp_item_type;

endpackage

/* design/ddp_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_req_if
// Input channel: one frame channel byte per beat.
// ----------------------------------------------------------------------------
interface ddp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

/* design/ddp_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_rsp_if
// Result channel: one packet stream byte per beat.
// ----------------------------------------------------------------------------
interface ddp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       packet_end;
   logic       frame_end;
   logic       run_last;

   modport source (output valid, output out_byte, output packet_end,
                   output frame_end, output run_last, input ready);
   modport sink (input valid, input out_byte, input packet_end,
                 input frame_end, input run_last, output ready);
endinterface

/* design/ddp_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_out_stage
// Output register that plays one item out as a data beat, after header beats when the item opens a packet.
// ----------------------------------------------------------------------------
module ddp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ddp_pkg::ddp_item_type item,
   output logic                  can_load,
   ddp_rsp_if.source             rsp
);

   ddp_pkg::ddp_item_type item_ff;
   logic                  valid_ff;
   logic                  valid_in;
   logic [3:0]            beat_ff;
   logic [3:0]            beat_in;
   logic                  fire;
   logic                  last_beat;

   assign fire      = valid_ff & rsp.ready;
   assign last_beat = (beat_ff == ddp_pkg::BEAT_DATA);
   assign can_load  = !valid_ff | (fire & last_beat);

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (fire) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 4'd1;
         end
      end
      if (load) begin
         valid_in = 1'b1;
         beat_in  = item.has_hdr ? ddp_pkg::BEAT_FLAGS : ddp_pkg::BEAT_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= ddp_pkg::BEAT_FLAGS;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   always_comb begin
      case (beat_ff)
         ddp_pkg::BEAT_FLAGS: rsp.out_byte = item_ff.flags;
         ddp_pkg::BEAT_SEQ:   rsp.out_byte = {4'd0, item_ff.seq};
         ddp_pkg::BEAT_TYPE:  rsp.out_byte = ddp_pkg::DATA_TYPE;
         ddp_pkg::BEAT_ID:    rsp.out_byte = ddp_pkg::DISPLAY_ID;
         ddp_pkg::BEAT_OFF3:  rsp.out_byte = item_ff.offset[31:24];
         ddp_pkg::BEAT_OFF2:  rsp.out_byte = item_ff.offset[23:16];
         ddp_pkg::BEAT_OFF1:  rsp.out_byte = item_ff.offset[15:8];
         ddp_pkg::BEAT_OFF0:  rsp.out_byte = item_ff.offset[7:0];
         ddp_pkg::BEAT_LEN1:  rsp.out_byte = {5'd0, item_ff.len[10:8]};
         ddp_pkg::BEAT_LEN0:  rsp.out_byte = item_ff.len[7:0];
         ddp_pkg::BEAT_DATA:  rsp.out_byte = item_ff.data;
         default:             rsp.out_byte = item_ff.data;
      endcase
   end

   assign rsp.valid      = valid_ff;
   assign rsp.packet_end = last_beat & item_ff.pend;
   assign rsp.frame_end  = last_beat & item_ff.fend;
   assign rsp.run_last   = last_beat;

`ifndef SYNTH
   a_load_ok: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || (rsp.ready && last_beat)))
      else $error("item loaded over a pending item");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded item not presented");
   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (beat_ff <= ddp_pkg::BEAT_DATA))
      else $error("beat index out of range");
   a_beat_step: assert property (@(posedge clock) disable iff (reset)
      (fire && !last_beat) |=> (beat_ff == $past(beat_ff) + 4'd1))
      else $error("header beat skipped");
`endif

endmodule

/* design/ddp_frame_packetizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_frame_packetizer_top
// Cuts a frame of channel bytes into packets with 10-byte headers.
// ----------------------------------------------------------------------------
// A byte that continues a packet leaves as one beat, so such bytes flow at one
// per cycle while the output is ready. A byte that opens a packet leaves as
// eleven beats (ten header bytes and the byte itself) through the single output
// register, holding the input; the next byte is taken in the cycle the last beat
// leaves. Dropped bytes (disabled, or empty frame) give no beat. Configuration
// must be written only while the block is idle; the block does not enforce it.
module ddp_frame_packetizer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ddp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ddp_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   ddp_req_if.sink                        req_ch,
   ddp_rsp_if.source                      rsp_ch
);

   logic        enabled_ff;
   logic [23:0] chan_count_ff;
   logic [24:0] start_chan_ff;
   logic        keep_off_ff;
   logic [10:0] pkt_size_ff;

   logic [23:0] frame_left_ff;
   logic [23:0] frame_left_in;
   logic [10:0] packet_left_ff;
   logic [10:0] packet_left_in;
   logic [3:0]  seq_ff;
   logic [3:0]  seq_in;
   logic [31:0] offset_ff;
   logic [31:0] offset_in;

   logic        accept;
   logic        can_load;
   logic        drop;
   logic        frame_new;
   logic        hdr;
   logic [23:0] fl;
   logic [31:0] off;
   logic [10:0] ps;
   logic [10:0] len;
   logic [10:0] pl;
   logic [10:0] pl_dec;
   logic [23:0] fl_dec;
   logic        load;
   ddp_pkg::ddp_item_type item;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         chan_count_ff <= 24'd0;
         start_chan_ff <= 25'd1;
         keep_off_ff   <= 1'b0;
         pkt_size_ff   <= ddp_pkg::MAX_PAYLOAD;
      end else if (csr_wr_en) begin
         case (csr_index)
            ddp_pkg::CSR_ENABLED:     enabled_ff    <= csr_wr_data[0];
            ddp_pkg::CSR_CHAN_COUNT:  chan_count_ff <= csr_wr_data[23:0];
            ddp_pkg::CSR_START_CHAN:  start_chan_ff <= csr_wr_data[24:0];
            ddp_pkg::CSR_KEEP_OFFSET: keep_off_ff   <= csr_wr_data[0];
            ddp_pkg::CSR_PKT_SIZE:    pkt_size_ff   <= csr_wr_data[10:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid & can_load;

   always_comb begin
      frame_new = (frame_left_ff == 24'd0);
      drop      = !enabled_ff | (frame_new & (chan_count_ff == 24'd0));
      fl        = frame_new ? chan_count_ff : frame_left_ff;
      if (!frame_new) begin
         off = offset_ff;
      end else if (keep_off_ff) begin
         off = {7'd0, start_chan_ff} - 32'd1;
      end else begin
         off = 32'd0;
      end
      hdr = (packet_left_ff == 11'd0);
      if (pkt_size_ff == 11'd0) begin
         ps = 11'd1;
      end else if (pkt_size_ff > ddp_pkg::MAX_PAYLOAD) begin
         ps = ddp_pkg::MAX_PAYLOAD;
      end else begin
         ps = pkt_size_ff;
      end
      len    = (fl < {13'd0, ps}) ? fl[10:0] : ps;
      pl     = hdr ? len : packet_left_ff;
      pl_dec = pl - 11'd1;
      fl_dec = fl - 24'd1;
      load   = accept & !drop;

      item.has_hdr = hdr;
      item.flags   = ({13'd0, len} == fl) ? (ddp_pkg::FLAG_VERSION | ddp_pkg::FLAG_PUSH)
                                         : ddp_pkg::FLAG_VERSION;
      item.seq     = seq_ff;
      item.offset  = off;
      item.len     = len;
      item.data    = req_ch.data_byte;
      item.fend    = (fl_dec == 24'd0);
      item.pend    = (pl_dec == 11'd0) | item.fend;

      frame_left_in  = frame_left_ff;
      packet_left_in = packet_left_ff;
      seq_in         = seq_ff;
      offset_in      = offset_ff;
      if (load) begin
         frame_left_in  = fl_dec;
         packet_left_in = item.fend ? 11'd0 : pl_dec;
         offset_in      = off + 32'd1;
         if (hdr) begin
            seq_in = (seq_ff >= ddp_pkg::SEQ_MAX) ? ddp_pkg::SEQ_FIRST : seq_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_left_ff  <= 24'd0;
         packet_left_ff <= 11'd0;
         seq_ff         <= ddp_pkg::SEQ_FIRST;
         offset_ff      <= 32'd0;
      end else begin
         frame_left_ff  <= frame_left_in;
         packet_left_ff <= packet_left_in;
         seq_ff         <= seq_in;
         offset_ff      <= offset_in;
      end
   end

   ddp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .item     (item),
      .can_load (can_load),
      .rsp      (rsp_ch)
   );

`ifndef SYNTH
   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      (seq_ff >= ddp_pkg::SEQ_FIRST) && (seq_ff <= ddp_pkg::SEQ_MAX))
      else $error("sequence number out of range");
   a_pkt_in_frame: assert property (@(posedge clock) disable iff (reset)
      {13'd0, packet_left_ff} <= frame_left_ff)
      else $error("packet runs past frame end");
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      (load && item.fend) |=> (frame_left_ff == 24'd0) && (packet_left_ff == 11'd0))
      else $error("frame end did not close the packet");
`endif

endmodule

/* sim/ddp_frame_packetizer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddp_frame_packetizer_top_tb
// Self-checking bench for the display protocol packetizer. Channel bytes are
// streamed in under many register settings. A behavioral packetizer turns
// every accepted byte into the header and payload beats it should produce,
// and the output beats are checked against them in order. Both channels
// idle and stall at random, except near the end of the run.
// ----------------------------------------------------------------------------
module ddp_frame_packetizer_top_tb;
   import ddp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_BYTES = 70;

   typedef struct {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       frame_end;
      logic       run_last;
   } packet_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   ddp_req_if req_ch ();
   ddp_rsp_if rsp_ch ();

   ddp_frame_packetizer_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // register copies and frame state of the behavioral packetizer
   logic        cfg_enabled;
   logic [23:0] cfg_count;
   logic [24:0] cfg_start;
   logic        cfg_keep;
   logic [10:0] cfg_psize;
   logic [23:0] frame_left;
   logic [10:0] packet_left;
   logic [3:0]  seq_number;
   logic [31:0] chan_offset;

   logic [7:0]      bytes_to_send[$];
   packet_beat_type beats_due[$];

   bit calm = 1'b0;
   int mismatches = 0;
   int bytes_taken = 0;
   int beats_seen = 0;
   int packets_seen = 0;
   int settings_used = 0;
   int cycles = 0;

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic add_beat(input logic [7:0] b, input logic pend, input logic fend,
                           input logic last);
      packet_beat_type beat;
      beat.out_byte = b;
      beat.packet_end = pend;
      beat.frame_end = fend;
      beat.run_last = last;
      beats_due.push_back(beat);
   endtask

   task automatic packetize_byte(input logic [7:0] b);
      logic [10:0] ps;
      logic [10:0] len;
      logic [7:0] flags;
      logic pend;
      logic fend;
      if (!cfg_enabled) return;
      if (frame_left == 0) begin
         if (cfg_count == 0) return;
         frame_left = cfg_count;
         chan_offset = cfg_keep ? {7'd0, cfg_start} - 32'd1 : 32'd0;
      end
      if (packet_left == 0) begin
         ps = cfg_psize;
         if (ps == 0) ps = 11'd1;
         if (ps > MAX_PAYLOAD) ps = MAX_PAYLOAD;
         len = (frame_left < {13'd0, ps}) ? frame_left[10:0] : ps;
         flags = FLAG_VERSION;
         if ({13'd0, len} == frame_left) flags = flags | FLAG_PUSH;
         add_beat(flags, 1'b0, 1'b0, 1'b0);
         add_beat({4'd0, seq_number}, 1'b0, 1'b0, 1'b0);
         add_beat(DATA_TYPE, 1'b0, 1'b0, 1'b0);
         add_beat(DISPLAY_ID, 1'b0, 1'b0, 1'b0);
         add_beat(chan_offset[31:24], 1'b0, 1'b0, 1'b0);
         add_beat(chan_offset[23:16], 1'b0, 1'b0, 1'b0);
         add_beat(chan_offset[15:8], 1'b0, 1'b0, 1'b0);
         add_beat(chan_offset[7:0], 1'b0, 1'b0, 1'b0);
         add_beat({5'd0, len[10:8]}, 1'b0, 1'b0, 1'b0);
         add_beat(len[7:0], 1'b0, 1'b0, 1'b0);
         packet_left = len;
         seq_number = (seq_number >= SEQ_MAX) ? SEQ_FIRST : seq_number + 4'd1;
      end
      packet_left = packet_left - 11'd1;
      frame_left = frame_left - 24'd1;
      chan_offset = chan_offset + 32'd1;
      pend = (packet_left == 0);
      fend = (frame_left == 0);
      if (fend) packet_left = 11'd0;
      add_beat(b, pend | fend, fend, 1'b1);
   endtask

   // driver
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data_byte <= 8'd0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            bytes_taken++;
            packetize_byte(req_ch.data_byte);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
               req_ch.valid <= 1'b1;
               req_ch.data_byte <= bytes_to_send.pop_front();
               if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 14);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int stall_left = 0;
   always @(posedge clock) begin
      packet_beat_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_seen++;
            if (rsp_ch.packet_end) packets_seen++;
            if (beats_due.size() == 0) begin
               flag_mismatch($sformatf("beat %02h with nothing expected", rsp_ch.out_byte));
            end else begin
               want = beats_due.pop_front();
               if (rsp_ch.out_byte !== want.out_byte)
                  flag_mismatch($sformatf("out_byte %02h, want %02h", rsp_ch.out_byte,
                                          want.out_byte));
               if (rsp_ch.packet_end !== want.packet_end)
                  flag_mismatch($sformatf("packet_end %b, want %b", rsp_ch.packet_end,
                                          want.packet_end));
               if (rsp_ch.frame_end !== want.frame_end)
                  flag_mismatch($sformatf("frame_end %b, want %b", rsp_ch.frame_end,
                                          want.frame_end));
               if (rsp_ch.run_last !== want.run_last)
                  flag_mismatch($sformatf("run_last %b, want %b", rsp_ch.run_last,
                                          want.run_last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("ddp_frame_packetizer_top verification failed");
         $finish;
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ENABLED: cfg_enabled = val[0];
         CSR_CHAN_COUNT: cfg_count = val[23:0];
         CSR_START_CHAN: cfg_start = val[24:0];
         CSR_KEEP_OFFSET: cfg_keep = val[0];
         CSR_PKT_SIZE: cfg_psize = val[10:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic en, input logic [23:0] count,
                                input logic [24:0] start, input logic keep,
                                input logic [10:0] psize);
      csr_write(CSR_ENABLED, {24'd0, en});
      csr_write(CSR_CHAN_COUNT, {1'b0, count});
      csr_write(CSR_START_CHAN, start);
      csr_write(CSR_KEEP_OFFSET, {24'd0, keep});
      csr_write(CSR_PKT_SIZE, {14'd0, psize});
      settings_used++;
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (bytes_to_send.size() > 0 || req_ch.valid || beats_due.size() > 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_random(input int n);
      repeat (n) bytes_to_send.push_back(8'($urandom_range(0, 255)));
      wait_quiet();
   endtask

   initial begin
      int random_sent;
      logic en;
      logic [23:0] count;
      logic [24:0] start;
      logic [10:0] psize;
      int n;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_ENABLED;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'd0;
      rsp_ch.ready = 1'b0;
      cfg_enabled = 1'b0;
      cfg_count = 24'd0;
      cfg_start = 25'd1;
      cfg_keep = 1'b0;
      cfg_psize = MAX_PAYLOAD;
      frame_left = 24'd0;
      packet_left = 11'd0;
      seq_number = SEQ_FIRST;
      chan_offset = 32'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // disabled, then empty frame: bytes are dropped
      send_random(3);
      load_settings(1'b1, 24'd0, 25'd1, 1'b0, MAX_PAYLOAD);
      send_random(2);

      // short frame in packets of two, data extremes
      load_settings(1'b1, 24'd5, 25'd1, 1'b0, 11'd2);
      bytes_to_send = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01};
      wait_quiet();

      // size zero runs as one, start channel zero wraps the offset
      load_settings(1'b1, 24'd3, 25'd0, 1'b1, 11'd0);
      send_random(3);

      // oversize packet clamps, highest start channel
      load_settings(1'b1, 24'd4, 25'h1FF_FFFF, 1'b1, 11'h7FF);
      send_random(4);

      // settings change in the middle of a frame
      load_settings(1'b1, 24'd6, 25'd100, 1'b1, 11'd4);
      send_random(3);
      load_settings(1'b1, 24'd2, 25'd7, 1'b0, 11'd1);
      send_random(5);

      random_sent = 0;
      while (random_sent < RANDOM_BYTES) begin
         en = ($urandom_range(0, 7) != 0);
         case ($urandom_range(0, 9))
            0: count = 24'd0;
            1: count = 24'($urandom_range(25, 60));
            default: count = 24'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 5))
            0: start = 25'd0;
            1: start = 25'h1FF_FFFF;
            default: start = 25'($urandom_range(0, 32'h1FF_FFFF));
         endcase
         case ($urandom_range(0, 9))
            0: psize = 11'd0;
            1: psize = 11'($urandom_range(1441, 2047));
            2: psize = 11'($urandom_range(9, 1440));
            default: psize = 11'($urandom_range(1, 8));
         endcase
         load_settings(en, count, start, 1'($urandom_range(0, 1)), psize);
         n = $urandom_range(4, 18);
         send_random(n);
         if (en) random_sent += n;
      end

      // no idling from here on: close the open frame, then start the largest frame
      calm = 1'b1;
      csr_write(CSR_ENABLED, 25'd1);
      send_random(int'(frame_left));
      load_settings(1'b1, 24'hFF_FFFF, 25'h1FF_FFFF, 1'b1, MAX_PAYLOAD);
      send_random(20);

      $display("covered %0d input bytes under %0d register settings", bytes_taken,
               settings_used);
      $display("checked %0d output beats in %0d packets", beats_seen, packets_seen);
      if (mismatches == 0 && beats_due.size() == 0) begin
         $display("ddp_frame_packetizer_top verification clean");
      end else begin
         $display("%0d mismatches, %0d beats never seen", mismatches, beats_due.size());
         $display("ddp_frame_packetizer_top verification failed");
      end
      $finish;
   end

endmodule
